// ===== sv/wosc_pkg.sv =====
package wosc_pkg;

  // Waveform selector carried in tuser; codes above MODE_PULSE_SQR are unused.
  typedef enum logic [2:0] {
    MODE_SINE      = 3'd0,
    MODE_SAW       = 3'd1,
    MODE_SQUARE    = 3'd2,
    MODE_TRIANGLE  = 3'd3,
    MODE_PULSE_SAW = 3'd4,
    MODE_PULSE_SQR = 3'd5
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ARG,
    ST_ARGR,
    ST_PLO,
    ST_PHI,
    ST_PSUM,
    ST_C1,
    ST_C2,
    ST_C3,
    ST_C4,
    ST_ACC,
    ST_FIN,
    ST_FINR,
    ST_S53,
    ST_S53R,
    ST_DONE
  } state_e;

  localparam int MAX_HARMONICS = 64;
  localparam logic [6:0] HC_RESET = 7'd16;

  localparam int Q_ONE = 65536;
  localparam int SAMPLE_MAX = 524287;
  localparam int SAMPLE_MIN = -524288;

  // Cycle-fraction gains, Q32: pi/20 for the sine, 1/(2*pi) for the saw.
  localparam logic signed [30:0] K_SIN = 31'sd674651885;
  localparam logic signed [30:0] K_SAW = 31'sd683565276;
  localparam logic signed [30:0] CUBIC_GAIN = 31'sd1362166;
  localparam logic signed [30:0] TWO_PI_Q16 = 31'sd411775;
  localparam logic signed [33:0] PI_Q16 = 34'sd205887;
  localparam logic signed [33:0] HALF_PI_Q16 = 34'sd102944;

  // Exact truncating division by reciprocal: ceil(2^k / d), bounds checked
  // against the largest dividend of each use.
  localparam logic signed [30:0] RECIP7 = 31'sd2396746;     // k = 24
  localparam logic signed [30:0] RECIP53 = 31'sd40518560;   // k = 31
  localparam int RECIP_ONE = 1 << 24;

  // ceil(2^24 / i) for harmonic index i; entry 0 never read.
  localparam logic [24:0] RECIP_TBL [MAX_HARMONICS] = '{
    25'(0),
    25'((RECIP_ONE + 0) / 1),   25'((RECIP_ONE + 1) / 2),   25'((RECIP_ONE + 2) / 3),
    25'((RECIP_ONE + 3) / 4),   25'((RECIP_ONE + 4) / 5),   25'((RECIP_ONE + 5) / 6),
    25'((RECIP_ONE + 6) / 7),   25'((RECIP_ONE + 7) / 8),   25'((RECIP_ONE + 8) / 9),
    25'((RECIP_ONE + 9) / 10),  25'((RECIP_ONE + 10) / 11), 25'((RECIP_ONE + 11) / 12),
    25'((RECIP_ONE + 12) / 13), 25'((RECIP_ONE + 13) / 14), 25'((RECIP_ONE + 14) / 15),
    25'((RECIP_ONE + 15) / 16), 25'((RECIP_ONE + 16) / 17), 25'((RECIP_ONE + 17) / 18),
    25'((RECIP_ONE + 18) / 19), 25'((RECIP_ONE + 19) / 20), 25'((RECIP_ONE + 20) / 21),
    25'((RECIP_ONE + 21) / 22), 25'((RECIP_ONE + 22) / 23), 25'((RECIP_ONE + 23) / 24),
    25'((RECIP_ONE + 24) / 25), 25'((RECIP_ONE + 25) / 26), 25'((RECIP_ONE + 26) / 27),
    25'((RECIP_ONE + 27) / 28), 25'((RECIP_ONE + 28) / 29), 25'((RECIP_ONE + 29) / 30),
    25'((RECIP_ONE + 30) / 31), 25'((RECIP_ONE + 31) / 32), 25'((RECIP_ONE + 32) / 33),
    25'((RECIP_ONE + 33) / 34), 25'((RECIP_ONE + 34) / 35), 25'((RECIP_ONE + 35) / 36),
    25'((RECIP_ONE + 36) / 37), 25'((RECIP_ONE + 37) / 38), 25'((RECIP_ONE + 38) / 39),
    25'((RECIP_ONE + 39) / 40), 25'((RECIP_ONE + 40) / 41), 25'((RECIP_ONE + 41) / 42),
    25'((RECIP_ONE + 42) / 43), 25'((RECIP_ONE + 43) / 44), 25'((RECIP_ONE + 44) / 45),
    25'((RECIP_ONE + 45) / 46), 25'((RECIP_ONE + 46) / 47), 25'((RECIP_ONE + 47) / 48),
    25'((RECIP_ONE + 48) / 49), 25'((RECIP_ONE + 49) / 50), 25'((RECIP_ONE + 50) / 51),
    25'((RECIP_ONE + 51) / 52), 25'((RECIP_ONE + 52) / 53), 25'((RECIP_ONE + 53) / 54),
    25'((RECIP_ONE + 54) / 55), 25'((RECIP_ONE + 55) / 56), 25'((RECIP_ONE + 56) / 57),
    25'((RECIP_ONE + 57) / 58), 25'((RECIP_ONE + 58) / 59), 25'((RECIP_ONE + 59) / 60),
    25'((RECIP_ONE + 60) / 61), 25'((RECIP_ONE + 61) / 62), 25'((RECIP_ONE + 62) / 63)
  };

  typedef struct packed {
    logic signed [33:0] a;
    logic signed [30:0] b;
  } mul_req_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] phase;
    logic signed [19:0] shape;
  } core_req_t;

  typedef struct packed {
    logic               valid;
    logic signed [21:0] value;
  } core_rsp_t;

endpackage

// ===== sv/wosc_mul.sv =====
module wosc_mul
  import wosc_pkg::*;
(
  input  logic               clk_i,
  input  mul_req_t           req_i,
  output logic signed [64:0] prod_o
);

  logic signed [64:0] prod_q;

  // Product is registered; the sequencer reads it in the next cycle.
  always_ff @(posedge clk_i) begin
    prod_q <= 65'($signed(req_i.a)) * 65'($signed(req_i.b));
  end

  assign prod_o = prod_q;

endmodule

// ===== sv/wosc_core.sv =====
module wosc_core
  import wosc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  core_req_t          req_i,
  output logic               ready_o,
  input  logic [6:0]         cnt_i,
  input  logic               out_free_i,
  output core_rsp_t          rsp_o,
  output mul_req_t           mul_req_o,
  input  logic signed [64:0] mul_prod_i
);

  state_e state_q, state_d;

  logic [2:0]         mode_q, mode_d;
  logic signed [31:0] x_q, x_d;
  logic signed [19:0] p_q, p_d;
  logic [47:0]        v_q, v_d;
  logic [47:0]        lo_q, lo_d;
  logic [47:0]        a_q, a_d;
  logic [47:0]        ph_q, ph_d;
  logic [6:0]         i_q, i_d;
  logic signed [20:0] sum_q, sum_d;
  logic signed [19:0] ps0_q, ps0_d;
  logic signed [26:0] dn_q, dn_d;
  logic signed [17:0] s_q, s_d;
  logic signed [21:0] res_q, res_d;
  logic               pass_q, pass_d;
  logic               sub_q, sub_d;
  logic               neg_q, neg_d;

  logic [47:0]        pfull, poff;
  logic [15:0]        f_ph, f_off;
  logic signed [16:0] fm_half, fm_one;
  logic signed [18:0] cub_c;
  logic [18:0]        cub_mag;
  logic signed [19:0] dc;
  logic signed [19:0] arg_opnd;
  logic signed [33:0] arg;
  logic signed [33:0] quad_v;
  logic [17:0]        div_q;
  logic signed [22:0] n4;
  logic [22:0]        n4_mag;
  logic [18:0]        q7;
  logic signed [19:0] ps;
  logic signed [26:0] dn;
  logic [26:0]        dn_mag;
  logic [20:0]        q53;
  logic signed [30:0] k_coef;
  logic signed [17:0] saw_s;
  logic               sine_kind;

  // Phase product low 48 bits: lo half plus hi half shifted by 24.
  assign pfull = lo_q + {mul_prod_i[23:0], 24'b0};
  assign poff  = pfull + {p_q[15:0], 32'b0};
  assign f_off = poff[47:32];
  assign f_ph  = ph_q[47:32];

  assign fm_half = $signed({1'b0, f_ph} - 17'h08000);
  assign fm_one  = $signed({1'b0, f_ph} - 17'h10000);

  assign cub_c   = $signed(mul_prod_i[50:32]);
  assign cub_mag = cub_c[18] ? 19'(-cub_c) : 19'(cub_c);
  assign div_q   = mul_prod_i[41:24];

  assign dc = p_q[19] ? 20'sd0 : ((p_q > 20'sd65536) ? 20'sd65536 : p_q);
  assign arg_opnd = (mode_q == MODE_PULSE_SAW) ? p_q : (pass_q ? dc : 20'sd0);
  assign arg = 34'(x_q) - 34'($signed(mul_prod_i[38:16]));

  assign quad_v = 34'(x_q) + HALF_PI_Q16;

  assign n4     = {sum_q, 2'b00};
  assign n4_mag = n4[22] ? 23'(-n4) : 23'(n4);
  assign q7     = mul_prod_i[42:24];
  assign ps     = neg_q ? -$signed({1'b0, q7}) : $signed({1'b0, q7});
  assign dn     = (27'(ps0_q) - 27'(ps)) * 27'sd50;
  assign dn_mag = dn_q[26] ? 27'(-dn_q) : 27'(dn_q);
  assign q53    = mul_prod_i[51:31];

  assign saw_s = 18'(Q_ONE) - 18'({f_off, 1'b0});

  assign sine_kind = (mode_q == MODE_SINE) || (mode_q == MODE_PULSE_SAW) ||
                     (mode_q == MODE_PULSE_SQR);
  assign k_coef = sine_kind ? K_SIN : K_SAW;

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    x_d     = x_q;
    p_d     = p_q;
    v_d     = v_q;
    lo_d    = lo_q;
    a_d     = a_q;
    ph_d    = ph_q;
    i_d     = i_q;
    sum_d   = sum_q;
    ps0_d   = ps0_q;
    dn_d    = dn_q;
    s_d     = s_q;
    res_d   = res_q;
    pass_d  = pass_q;
    sub_d   = sub_q;
    neg_d   = neg_q;
    mul_req_o = '0;
    rsp_o.valid = 1'b0;
    rsp_o.value = res_q;
    ready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        ready_o = 1'b1;
        if (req_valid_i) begin
          mode_d = req_i.mode;
          x_d    = req_i.phase;
          p_d    = req_i.shape;
          sum_d  = '0;
          pass_d = 1'b0;
          sub_d  = 1'b0;
          unique case (req_i.mode)
            MODE_SINE, MODE_SAW, MODE_SQUARE: begin
              v_d = 48'(req_i.phase);
              state_d = ST_PLO;
            end
            MODE_TRIANGLE: begin
              v_d = 48'((34'(req_i.phase) <<< 1) + PI_Q16);
              state_d = ST_PLO;
            end
            MODE_PULSE_SAW, MODE_PULSE_SQR: state_d = ST_ARG;
            default: begin
              res_d = '0;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_ARG: begin
        mul_req_o.a = 34'(arg_opnd);
        mul_req_o.b = TWO_PI_Q16;
        state_d = ST_ARGR;
      end
      ST_ARGR: begin
        v_d = 48'(arg);
        state_d = ST_PLO;
      end
      ST_PLO: begin
        mul_req_o.a = {10'b0, v_q[23:0]};
        mul_req_o.b = k_coef;
        state_d = ST_PHI;
      end
      ST_PHI: begin
        lo_d = mul_prod_i[47:0];
        mul_req_o.a = {10'b0, v_q[47:24]};
        mul_req_o.b = k_coef;
        state_d = ST_PSUM;
      end
      ST_PSUM: begin
        unique case (mode_q)
          MODE_SINE: begin
            ph_d = pfull;
            state_d = ST_C1;
          end
          MODE_SAW: begin
            res_d = 22'(Q_ONE) - 22'({f_off, 1'b0});
            state_d = ST_DONE;
          end
          MODE_SQUARE: begin
            res_d = 22'({f_off, 1'b0}) - 22'({pfull[47:32], 1'b0}) + 22'(Q_ONE)
                    - (22'(p_q) <<< 1);
            state_d = ST_DONE;
          end
          MODE_TRIANGLE: begin
            if (!sub_q) begin
              s_d = saw_s;
              v_d = 48'(quad_v);
              sub_d = 1'b1;
              state_d = ST_PLO;
            end else begin
              // The half-duty square is +/-1 exactly, sign from bit 47 of
              // the cycle fraction, so the product reduces to +/-s.
              res_d = pfull[47] ? -22'(s_q) : 22'(s_q);
              state_d = ST_DONE;
            end
          end
          default: begin
            a_d  = pfull;
            ph_d = pfull;
            i_d  = 7'd1;
            state_d = (cnt_i > 7'd1) ? ST_C1 : ST_FIN;
          end
        endcase
      end
      ST_C1: begin
        mul_req_o.a = {18'b0, f_ph};
        mul_req_o.b = 31'(fm_half);
        state_d = ST_C2;
      end
      ST_C2: begin
        mul_req_o.a = mul_prod_i[33:0];
        mul_req_o.b = 31'(fm_one);
        state_d = ST_C3;
      end
      ST_C3: begin
        mul_req_o.a = mul_prod_i[49:16];
        mul_req_o.b = CUBIC_GAIN;
        state_d = ST_C4;
      end
      ST_C4: begin
        if (mode_q == MODE_SINE) begin
          res_d = 22'(cub_c);
          state_d = ST_DONE;
        end else begin
          neg_d = cub_c[18];
          mul_req_o.a = {15'b0, cub_mag};
          mul_req_o.b = {6'b0, RECIP_TBL[i_q[5:0]]};
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        sum_d = neg_q ? sum_q - 21'({3'b0, div_q}) : sum_q + 21'({3'b0, div_q});
        ph_d  = ph_q + a_q;
        i_d   = i_q + 7'd1;
        state_d = ((i_q + 7'd1) < cnt_i) ? ST_C1 : ST_FIN;
      end
      ST_FIN: begin
        neg_d = n4[22];
        mul_req_o.a = {11'b0, n4_mag};
        mul_req_o.b = RECIP7;
        state_d = ST_FINR;
      end
      ST_FINR: begin
        if (mode_q == MODE_PULSE_SAW) begin
          res_d = 22'(ps);
          state_d = ST_DONE;
        end else if (!pass_q) begin
          ps0_d  = ps;
          pass_d = 1'b1;
          sum_d  = '0;
          state_d = ST_ARG;
        end else begin
          dn_d = dn;
          state_d = ST_S53;
        end
      end
      ST_S53: begin
        neg_d = dn_q[26];
        mul_req_o.a = {7'b0, dn_mag};
        mul_req_o.b = RECIP53;
        state_d = ST_S53R;
      end
      ST_S53R: begin
        res_d = neg_q ? -$signed({1'b0, q53}) : $signed({1'b0, q53});
        state_d = ST_DONE;
      end
      ST_DONE: begin
        rsp_o.valid = 1'b1;
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    x_q    <= x_d;
    p_q    <= p_d;
    v_q    <= v_d;
    lo_q   <= lo_d;
    a_q    <= a_d;
    ph_q   <= ph_d;
    i_q    <= i_d;
    sum_q  <= sum_d;
    ps0_q  <= ps0_d;
    dn_q   <= dn_d;
    s_q    <= s_d;
    res_q  <= res_d;
    pass_q <= pass_d;
    sub_q  <= sub_d;
    neg_q  <= neg_d;
  end

endmodule

// ===== sv/waveform_oscillator_sample.sv =====
// Waveform oscillator: each request on the slave stream yields one signed Q3.16
// sample on the master stream. tuser selects the waveform (cubic sine, saw,
// square, triangle, band-limited pulse saw, band-limited pulse square); tdata
// carries the Q15.16 phase in radians and a Q3.16 shape value (phase offset or
// duty). All arithmetic runs through one registered 34x31 multiplier stepped by
// a small sequencer, so one request is worked on at a time and s_axis_tready is
// low while it is. The pulse modes step the multiplier through states C1, C2,
// C3, C4 and ACC once per harmonic; pulse square runs the harmonic loop twice,
// and the harmonic count is clamped to 64. The finished sample sits in an
// output register, so a new request is taken while it waits on m_axis_tready.
// cfg_we_i loads the harmonic count (reset 16); change it only while the block
// is idle.
module waveform_oscillator_sample
  import wosc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // [31:0] phase, [51:32] shape_param, rest zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [19:0] sample, rest zero
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i
);

  logic [6:0]         hc_q;
  logic [6:0]         cnt;
  logic               out_valid_q, out_valid_d;
  logic signed [19:0] sample_q, sample_d;
  logic               out_free;
  logic               core_ready;
  core_req_t          core_req;
  core_rsp_t          core_rsp;
  mul_req_t           mul_req;
  logic signed [64:0] mul_prod;

  // Harmonic count register; counts above the table size act as the maximum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q <= HC_RESET;
    end else if (cfg_we_i) begin
      hc_q <= cfg_wdata_i;
    end
  end

  assign cnt = (hc_q > 7'(MAX_HARMONICS)) ? 7'(MAX_HARMONICS) : hc_q;

  assign core_req.mode  = s_axis_tuser;
  assign core_req.phase = $signed(s_axis_tdata[31:0]);
  assign core_req.shape = $signed(s_axis_tdata[51:32]);
  assign s_axis_tready  = core_ready;

  // Output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_q || m_axis_tready;

  wosc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_i       (core_req),
    .ready_o     (core_ready),
    .cnt_i       (cnt),
    .out_free_i  (out_free),
    .rsp_o       (core_rsp),
    .mul_req_o   (mul_req),
    .mul_prod_i  (mul_prod)
  );

  wosc_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (mul_prod)
  );

  // Saturate the wide result into the 20-bit sample on load.
  always_comb begin
    out_valid_d = out_valid_q;
    sample_d    = sample_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (core_rsp.valid && out_free) begin
      out_valid_d = 1'b1;
      if (core_rsp.value > 22'(SAMPLE_MAX)) begin
        sample_d = 20'(SAMPLE_MAX);
      end else if (core_rsp.value < 22'(SAMPLE_MIN)) begin
        sample_d = 20'(SAMPLE_MIN);
      end else begin
        sample_d = core_rsp.value[19:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, sample_q};

`ifndef SYNTHESIS
  // Once a request is taken the sequencer is busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("block ready right after accepting a request");

  // A finished result is never offered while a new request could be taken.
  a_no_result_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_rsp.valid |-> !s_axis_tready)
    else $error("result offered while idle");

  // Unused modes skip the datapath and finish on the next cycle.
  a_unused_mode_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser > MODE_PULSE_SQR)
    |=> core_rsp.valid)
    else $error("unused mode did not finish at once");

  // A result handed over while the output register was full must not be lost.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("pending sample overwritten");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  // Fixed-point constants for the sample predictor: Q32 rates, the rest Q16
  localparam longint SINE_RATE = 64'd674651885;   // 2^32 * pi/20
  localparam longint SAW_RATE = 64'd683565276;    // 2^32 / (2*pi)
  localparam longint CUBIC_SCALE = 64'd1362166;   // 20.785
  localparam longint PI_FX = 64'd205887;
  localparam longint HALF_PI_FX = 64'd102944;
  localparam longint TWO_PI_FX = 64'd411775;
  localparam longint ONE_FX = 64'd65536;
  localparam longint HALF_FX = 64'd32768;
  localparam longint OUT_MAX = 64'd524287;
  localparam longint OUT_MIN = -64'sd524288;
  localparam longint HARMONIC_CAP = wosc_pkg::MAX_HARMONICS;

  localparam logic [6:0] HC_AT_RESET = 7'd16;
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  localparam int PHASE_ITEMS = 98;
  localparam int HC_PHASES = 10;
  localparam int CALM_TAIL = 100;     // no idling once this few entries remain
  localparam int DRAIN_CYCLES = 700;  // longer than a 64-harmonic pulse square

  // One entry of the stimulus list: either a request or a harmonic count write.
  typedef struct packed {
    logic        hc_write;
    logic [6:0]  hc_value;
    logic [2:0]  mode;
    logic [31:0] phase;
    logic [19:0] shape;
  } osc_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;   // [31:0] phase, [51:32] shape_param, rest zero
  logic [2:0]  s_axis_tuser = '0;   // [2:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [19:0] sample, rest zero
  logic        cfg_we_i = 1'b0;
  logic [6:0]  cfg_wdata_i = '0;

  osc_req_t    pending[$];
  logic [19:0] samples_due[$];
  logic [6:0]  hc_model = HC_AT_RESET;
  int          n_sent = 0;
  int          n_recv = 0;
  int          mismatches = 0;
  int          src_gap = 0;
  int          snk_gap = 0;
  logic        calm = 1'b0;

  waveform_oscillator_sample dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // Cubic sine: fraction of x*pi/20 per cycle, f*(f-1/2)*(f-1)*20.785.
  function automatic longint cubic_tone(longint x);
    longint prod;
    longint f;
    longint abc;
    prod = x * SINE_RATE;
    f = (prod >> 32) & 64'hFFFF;
    abc = f * (f - HALF_FX) * (f - ONE_FX);
    return ((abc >>> 16) * CUBIC_SCALE) >>> 32;
  endfunction

  // Saw: 1 - 2*frac(x/(2*pi) + p); the wrap is floor based.
  function automatic longint saw_tone(longint x, longint p);
    longint prod;
    longint f;
    prod = x * SAW_RATE + (p <<< 32);
    f = (prod >> 32) & 64'hFFFF;
    return ONE_FX - 2 * f;
  endfunction

  // Square as the difference of two saws, duty not clamped.
  function automatic longint square_tone(longint x, longint d);
    return saw_tone(x, 0) - saw_tone(x, d) + 2 * (HALF_FX - d);
  endfunction

  function automatic longint triangle_tone(longint x, longint p);
    longint s;
    longint q;
    s = saw_tone(2 * x + PI_FX, p);
    q = square_tone(x + HALF_PI_FX, HALF_FX);
    return (s * q) >>> 16;
  endfunction

  // Band-limited saw: sum of harmonics 1..n-1, each over its index, times 4/7.
  function automatic longint pulse_saw_tone(longint x, longint p, longint n);
    longint arg;
    longint sum;
    arg = x - ((p * TWO_PI_FX) >>> 16);
    sum = 0;
    for (longint i = 1; i < n; i++) sum += cubic_tone(arg * i) / i;
    return sum * 4 / 7;
  endfunction

  // Band-limited square: duty clamped to 0..1, scaled by 50/53.
  function automatic longint pulse_square_tone(longint x, longint d, longint n);
    longint dc;
    dc = (d > ONE_FX) ? ONE_FX : ((d < 0) ? 64'd0 : d);
    return (pulse_saw_tone(x, 0, n) - pulse_saw_tone(x, dc, n)) * 50 / 53;
  endfunction

  function automatic logic [19:0] predict_sample(logic [2:0] mode, logic [31:0] phase,
                                                 logic [19:0] shape, logic [6:0] count);
    longint x;
    longint p;
    longint n;
    longint r;
    x = longint'($signed(phase));
    p = longint'($signed(shape));
    n = (count > HARMONIC_CAP) ? HARMONIC_CAP : longint'(count);
    case (mode)
      wosc_pkg::MODE_SINE:      r = cubic_tone(x);
      wosc_pkg::MODE_SAW:       r = saw_tone(x, p);
      wosc_pkg::MODE_SQUARE:    r = square_tone(x, p);
      wosc_pkg::MODE_TRIANGLE:  r = triangle_tone(x, p);
      wosc_pkg::MODE_PULSE_SAW: r = pulse_saw_tone(x, p, n);
      wosc_pkg::MODE_PULSE_SQR: r = pulse_square_tone(x, p, n);
      default:                  r = 0;
    endcase
    if (r > OUT_MAX) r = OUT_MAX;
    else if (r < OUT_MIN) r = OUT_MIN;
    return r[19:0];
  endfunction

  // ------------------------------------------------------------------ driver

  // Requests go out in list order. A harmonic count write waits until the
  // block has returned every sample, which also gives the drain-pause case.
  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt_valid;
    logic nxt_we;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
      cfg_we_i <= 1'b0;
      cfg_wdata_i <= '0;
      calm <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) n_sent++;
      nxt_valid = s_axis_tvalid && !s_axis_tready;
      nxt_we = 1'b0;
      if (!nxt_valid && pending.size() != 0) begin
        if (pending[0].hc_write) begin
          if (!s_axis_tvalid && n_sent == n_recv) begin
            nxt_we = 1'b1;
            cfg_wdata_i <= pending[0].hc_value;
            void'(pending.pop_front());
          end
        end else if (src_gap != 0) begin
          src_gap--;
        end else if (pending.size() >= CALM_TAIL && $urandom_range(0, 5) == 0) begin
          // this cycle idles too, ahead of the random gap set here
          src_gap = $urandom_range(0, 11);
        end else begin
          nxt_valid = 1'b1;
          s_axis_tdata <= {4'b0, pending[0].shape, pending[0].phase};
          s_axis_tuser <= pending[0].mode;
          void'(pending.pop_front());
        end
      end
      s_axis_tvalid <= nxt_valid;
      cfg_we_i <= nxt_we;
      calm <= (pending.size() < CALM_TAIL);
    end
  end

  // Sample sink: random back-pressure bursts, none near the end.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      snk_gap <= 0;
    end else if (snk_gap != 0) begin
      snk_gap <= snk_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      snk_gap <= $urandom_range(0, 11);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ----------------------------------------------------------------- monitor

  // Results are checked before new requests are predicted, so a sample that
  // turns up with nothing waiting is never matched against a fresh entry.
  always @(posedge clk_i) begin
    logic [19:0] want;
    if (rst_ni) begin
      if (cfg_we_i) hc_model = cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) begin
        n_recv <= n_recv + 1;
        if (samples_due.size() == 0) begin
          mismatches++;
          $display("%0t: sample with no request waiting, expected none actual %0d",
                   $time, $signed(m_axis_tdata[19:0]));
        end else begin
          want = samples_due.pop_front();
          if (m_axis_tdata[19:0] !== want) begin
            mismatches++;
            $display("%0t: sample mismatch, expected %0d actual %0d",
                     $time, $signed(want), $signed(m_axis_tdata[19:0]));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        samples_due.push_back(predict_sample(s_axis_tuser, s_axis_tdata[31:0],
                                             s_axis_tdata[51:32], hc_model));
    end
  end

  // --------------------------------------------------------------- stimulus

  task automatic queue_tone(logic [2:0] mode, logic [31:0] phase, logic [19:0] shape);
    osc_req_t req;
    req = '0;
    req.mode = mode;
    req.phase = phase;
    req.shape = shape;
    pending.push_back(req);
  endtask

  initial begin
    int       hc_plan[HC_PHASES - 1] = '{0, 1, 2, 127, 64, 65, 3, 9, 33};
    osc_req_t req;

    // Directed requests at the reset harmonic count
    queue_tone(wosc_pkg::MODE_SINE, 32'd0, 20'd0);
    queue_tone(wosc_pkg::MODE_SINE, 32'h7FFF_FFFF, 20'h7FFFF);   // shape ignored
    queue_tone(wosc_pkg::MODE_SINE, 32'h8000_0000, 20'h80000);
    queue_tone(wosc_pkg::MODE_SINE, 32'hFFFF_FFFF, 20'd0);       // just below zero
    queue_tone(wosc_pkg::MODE_SINE, 32'd102944, 20'd0);
    queue_tone(wosc_pkg::MODE_SAW, 32'd0, 20'd0);
    queue_tone(wosc_pkg::MODE_SAW, 32'h7FFF_FFFF, 20'h7FFFF);
    queue_tone(wosc_pkg::MODE_SAW, 32'h8000_0000, 20'h80000);
    queue_tone(wosc_pkg::MODE_SQUARE, 32'd65536, 20'd32768);
    queue_tone(wosc_pkg::MODE_SQUARE, 32'(-200000), 20'h80000);  // saturates high
    queue_tone(wosc_pkg::MODE_SQUARE, 32'd300000, 20'h7FFFF);    // saturates low
    queue_tone(wosc_pkg::MODE_TRIANGLE, 32'd0, 20'd0);
    queue_tone(wosc_pkg::MODE_TRIANGLE, 32'h8000_0000, 20'd16384);
    queue_tone(wosc_pkg::MODE_TRIANGLE, 32'h7FFF_FFFF, 20'hF0000);
    queue_tone(wosc_pkg::MODE_PULSE_SAW, 32'd0, 20'd0);
    queue_tone(wosc_pkg::MODE_PULSE_SAW, 32'h8000_0000, 20'h7FFFF);
    queue_tone(wosc_pkg::MODE_PULSE_SQR, 32'd77777, 20'(-65536)); // duty clamps to 0
    queue_tone(wosc_pkg::MODE_PULSE_SQR, 32'd77777, 20'd131072);  // duty clamps to 1
    queue_tone(wosc_pkg::MODE_PULSE_SQR, 32'd150000, 20'd16384);
    queue_tone(wosc_pkg::MODE_PULSE_SQR, 32'hFFFE_0000, 20'h7FFFF);
    queue_tone(MODE_SPARE_A, 32'hFFFF_FFFF, 20'hFFFFF);
    queue_tone(MODE_SPARE_B, 32'h1234_5678, 20'h5A5A5);

    // Random phases, each behind a new harmonic count
    for (int ph = 0; ph < HC_PHASES; ph++) begin
      req = '0;
      req.hc_write = 1'b1;
      req.hc_value = (ph < HC_PHASES - 1) ? 7'(hc_plan[ph]) : 7'($urandom_range(4, 24));
      pending.push_back(req);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        req = '0;
        req.mode = ($urandom_range(0, 99) < 96) ? 3'($urandom_range(0, 5))
                                                : 3'($urandom_range(6, 7));
        case ($urandom_range(0, 3))
          0:       req.phase = $urandom;
          1:       req.phase = 32'(int'($urandom_range(0, 1048576)) - 524288);
          2:       req.phase = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
                                                    : 32'h8000_0000 + $urandom_range(0, 255);
          default: req.phase = 32'(int'($urandom_range(0, 131072)) - 65536);
        endcase
        case ($urandom_range(0, 2))
          0:       req.shape = 20'($urandom);
          1:       req.shape = 20'($urandom_range(0, 65536));
          default: req.shape = 20'(int'($urandom_range(0, 196608)) - 65536);
        endcase
        pending.push_back(req);
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pending.size() != 0 || s_axis_tvalid || n_sent != n_recv);
    // catch any sample the block makes on its own after the last one
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatches == 0 && samples_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #50_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
